// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared request, status and sequencer types for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int WORD_W = 32;  // width of the data word on both channels
  localparam int POS_W  = 4;   // width of the read position
  localparam int LEN_W  = 5;   // width of the reported length

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_TAKE   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_BAD_INDEX = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_SCAN,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    status_t           status;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of words with put, take, indexed read and
// remove-by-value at either end.
// ----------------------------------------------------------------------------
// Usage: a request item enters on the s_axis channel and exactly one result
// item leaves on the m_axis channel for each request, in order. The request
// names an operation and an end; the result carries the word taken, read or
// removed (zero on a put or an error), a status code and the length held
// after the request.
// The words live in a circular store with a single access per cycle, walked
// by a small sequencer. A put is written in S_DECODE and reported from S_DONE;
// a take or read is issued in S_DECODE and its word captured in S_FETCH; an
// empty, full or bad-index request goes from S_DECODE straight to S_DONE. A
// remove reads words from the chosen end in S_SCAN and compares them in S_CMP
// until one matches, then closes the gap through S_SHIFT_RD and S_SHIFT_WR,
// moving each word between the match and the tail one slot toward the head.
// One request is in work at a time; s_axis_tready is low from acceptance
// until the result is handed to the output register and rises the cycle after.
// Reset (rst, synchronous, active high) empties the queue and drops any
// pending result. The store itself is not cleared; only words below the
// current length are ever read. When the receiver stalls, the result waits
// in the output register and the next request may still be accepted and
// worked on; its result waits until the register is free.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // data_value[31:0], position[35:32], zero pad
  input  wire logic [2:0]  s_axis_tuser,   // req_type[1:0], from_tail[2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // out_word[31:0], length[36:32], zero pad
  output logic      [2:0]  m_axis_tuser    // status[2:0]
);

  // Stored word width: requests carry at most WORD_W bits.
  localparam int SW = (DATA_W < WORD_W) ? DATA_W : WORD_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic          res_valid;
  logic          res_ready;
  result_t       result;
  result_t       out_q;
  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_addr;
  logic [SW-1:0] mem_wr_data, mem_rd_data;

  deq_seq #(
    .DEPTH (DEPTH),
    .SW    (SW),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_axis_tvalid),
    .req_ready   (s_axis_tready),
    .req_type    (req_t'(s_axis_tuser[1:0])),
    .from_tail   (s_axis_tuser[2]),
    .data_value  (s_axis_tdata[SW-1:0]),
    .position    (s_axis_tdata[WORD_W +: POS_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .result      (result),
    .mem_wr_en   (mem_wr_en),
    .mem_rd_en   (mem_rd_en),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  deq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (SW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .rd_en   (mem_rd_en),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= result;
    end
  end

  assign m_axis_tdata = {3'b000, out_q.length, out_q.word};
  assign m_axis_tuser = out_q.status;

endmodule
`default_nettype wire

// File: rtl/core/deq_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_mem
// Word storage of the queue: one write and one registered read per cycle, on one shared address.
// ----------------------------------------------------------------------------
module deq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/deq_addr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_addr
// Maps a position counted from the head onto a slot of the circular store.
// ----------------------------------------------------------------------------
module deq_addr #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic [AW-1:0] head,
  input  wire logic [AW-1:0] lidx,
  output logic      [AW-1:0] phys
);

  logic [AW:0] sum;

  always_comb begin
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    phys = sum[AW-1:0];
  end

endmodule
`default_nettype wire

// File: rtl/core/deq_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_seq
// Request sequencer: head pointer, count, search and gap-closing loops.
// ----------------------------------------------------------------------------
module deq_seq
  import deq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int SW    = 32,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req_type,
  input  wire logic              from_tail,
  input  wire logic [SW-1:0]     data_value,
  input  wire logic [POS_W-1:0]  position,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output result_t                result,
  output logic                   mem_wr_en,
  output logic                   mem_rd_en,
  output logic      [AW-1:0]     mem_addr,
  output logic      [SW-1:0]     mem_wr_data,
  input  wire logic [SW-1:0]     mem_rd_data
);

  localparam int LW = (CW > POS_W) ? CW : POS_W;

  state_t           state, state_next;
  logic [AW-1:0]    hd;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    j;
  req_t             op;
  logic             tail;
  logic [SW-1:0]    val;
  logic [POS_W-1:0] pos;
  logic [SW-1:0]    word;
  status_t          stat;

  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    last_idx;
  logic [AW-1:0]    hd_inc, hd_dec, j_inc;
  logic [LW-1:0]    pos_w, tail_pos;
  logic             full, bad_pos, hit, last_scan;
  logic [AW-1:0]    scan_k, read_idx, lidx, phys;
  logic             put_head;

  assign cnt_m1    = cnt - CW'(1);
  assign last_idx  = cnt_m1[AW-1:0];
  assign hd_inc    = (hd == AW'(DEPTH - 1)) ? '0 : hd + AW'(1);
  assign hd_dec    = (hd == '0) ? AW'(DEPTH - 1) : hd - AW'(1);
  assign j_inc     = j + AW'(1);
  assign full      = (cnt == CW'(DEPTH));
  assign pos_w     = LW'(pos);
  assign tail_pos  = LW'(cnt_m1) - pos_w;
  assign bad_pos   = (pos_w >= LW'(cnt));
  assign read_idx  = tail ? tail_pos[AW-1:0] : pos_w[AW-1:0];
  assign scan_k    = tail ? (last_idx - j) : j;
  assign last_scan = (j == last_idx);
  assign hit       = (mem_rd_data == val);
  assign put_head  = (state == S_DECODE) && (op == REQ_PUT) && !tail;

  deq_addr #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_addr (
    .head (hd),
    .lidx (lidx),
    .phys (phys)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (op == REQ_PUT || cnt == '0) begin
          state_next = S_DONE;
        end else if (op == REQ_REMOVE) begin
          state_next = S_SCAN;
        end else if (op == REQ_READ && bad_pos) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH:    state_next = S_DONE;
      S_SCAN:     state_next = S_CMP;
      S_CMP: begin
        if (hit) begin
          state_next = (scan_k != last_idx) ? S_SHIFT_RD : S_DONE;
        end else begin
          state_next = last_scan ? S_DONE : S_SCAN;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (j_inc != last_idx) ? S_SHIFT_RD : S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs: storage access and handshakes.
  always_comb begin
    lidx        = '0;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_data = val;
    unique case (state)
      S_DECODE: begin
        if (op == REQ_PUT) begin
          mem_wr_en = !full;
          lidx      = cnt[AW-1:0];
        end else if (cnt != '0) begin
          if (op == REQ_TAKE) begin
            mem_rd_en = 1'b1;
            lidx      = tail ? last_idx : '0;
          end else if (op == REQ_READ) begin
            mem_rd_en = !bad_pos;
            lidx      = read_idx;
          end
        end
      end
      S_SCAN: begin
        mem_rd_en = 1'b1;
        lidx      = scan_k;
      end
      S_SHIFT_RD: begin
        mem_rd_en = 1'b1;
        lidx      = j_inc;
      end
      S_SHIFT_WR: begin
        mem_wr_en   = 1'b1;
        lidx        = j;
        mem_wr_data = mem_rd_data;
      end
      default: begin
      end
    endcase
    mem_addr = put_head ? hd_dec : phys;
  end

  assign req_ready     = (state == S_IDLE);
  assign res_valid     = (state == S_DONE);
  assign result.word   = WORD_W'(word);
  assign result.status = stat;
  assign result.length = LEN_W'(cnt);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hd    <= '0;
      cnt   <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_DECODE: begin
          j <= '0;
          if (op == REQ_PUT && !full) begin
            cnt <= cnt + CW'(1);
            if (!tail) begin
              hd <= hd_dec;
            end
          end
        end
        S_FETCH: begin
          if (op == REQ_TAKE) begin
            cnt <= cnt_m1;
            if (!tail) begin
              hd <= hd_inc;
            end
          end
        end
        S_CMP: begin
          if (hit) begin
            if (scan_k != last_idx) begin
              j <= scan_k;
            end else begin
              cnt <= cnt_m1;
            end
          end else if (!last_scan) begin
            j <= j_inc;
          end
        end
        S_SHIFT_WR: begin
          j <= j_inc;
          if (j_inc == last_idx) begin
            cnt <= cnt_m1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op   <= req_type;
          tail <= from_tail;
          val  <= data_value;
          pos  <= position;
        end
      end
      S_DECODE: begin
        word <= '0;
        if (op == REQ_PUT) begin
          stat <= full ? STAT_FULL : STAT_OK;
        end else if (cnt == '0) begin
          stat <= STAT_EMPTY;
        end else if (op == REQ_READ && bad_pos) begin
          stat <= STAT_BAD_INDEX;
        end else begin
          stat <= STAT_OK;
        end
      end
      S_FETCH: begin
        word <= mem_rd_data;
      end
      S_CMP: begin
        if (hit) begin
          word <= mem_rd_data;
        end else if (last_scan) begin
          stat <= STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended queue with random flow control.
// ----------------------------------------------------------------------------
// A short directed list drives the queue through empty, single-word and full
// conditions. A long random phase follows. It swings between filling and
// draining so that the length sweeps its whole range. Each accepted request
// is run through a queue-based predictor. Each result item is compared field
// by field with the oldest prediction. Both channels idle at random, and
// there are calm stretches in which neither side stalls.
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_REQS = 1920;
  localparam int CYCLE_LIMIT = 1_200_000;
  // A remove walks and shifts at most the whole store.
  localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH + 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [39:0] req_data = '0;   // data_value[31:0], position[35:32], zero pad
  logic [2:0]  req_user = '0;   // req_type[1:0], from_tail[2]
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [39:0] rsp_data;        // out_word[31:0], length[36:32], zero pad
  logic [2:0]  rsp_user;        // status[2:0]

  // Shadow copy of the queue contents, index 0 at the head end.
  logic [WORD_W-1:0] shadow_words[$];
  result_t           pending_results[$];
  result_t           oldest_result;
  int                errors = 0;
  int                cycles = 0;
  int                stall_left = 0;
  int                sink_gap;
  logic              calm;

  // One row of the directed list. Rows with "typed" set carry a result that
  // is obvious by inspection; the others take the predictor's answer.
  typedef struct {
    req_t        op;
    bit          tail;
    logic [31:0] val;
    logic [3:0]  pos;
    int          reps;
    bit          typed;
    logic [31:0] want_word;
    status_t     want_status;
    int          want_len;
  } plan_row_t;

  plan_row_t plan[] = '{
    '{REQ_TAKE,   1'b0, 32'h0,         4'd0,  1, 1'b1, 32'h0,         STAT_EMPTY,      0},
    '{REQ_TAKE,   1'b1, 32'h0,         4'd0,  1, 1'b1, 32'h0,         STAT_EMPTY,      0},
    '{REQ_READ,   1'b0, 32'h0,         4'd0,  1, 1'b1, 32'h0,         STAT_EMPTY,      0},
    '{REQ_REMOVE, 1'b1, 32'h0,         4'd15, 1, 1'b1, 32'h0,         STAT_EMPTY,      0},
    '{REQ_PUT,    1'b1, 32'h0,         4'd0,  1, 1'b1, 32'h0,         STAT_OK,         1},
    '{REQ_TAKE,   1'b0, 32'h0,         4'd0,  1, 1'b1, 32'h0,         STAT_OK,         0},
    '{REQ_PUT,    1'b0, 32'hFFFF_FFFF, 4'd0,  1, 1'b1, 32'h0,         STAT_OK,         1},
    '{REQ_TAKE,   1'b1, 32'h0,         4'd0,  1, 1'b1, 32'hFFFF_FFFF, STAT_OK,         0},
    '{REQ_PUT,    1'b1, 32'hA5A5_0000, 4'd0,  8, 1'b0, 32'h0,         STAT_OK,         0},
    '{REQ_PUT,    1'b0, 32'h5A5A_0000, 4'd0,  8, 1'b0, 32'h0,         STAT_OK,         0},
    '{REQ_PUT,    1'b1, 32'h1234_5678, 4'd0,  1, 1'b1, 32'h0,         STAT_FULL,       16},
    '{REQ_PUT,    1'b0, 32'h8765_4321, 4'd0,  1, 1'b1, 32'h0,         STAT_FULL,       16},
    '{REQ_READ,   1'b0, 32'h0,         4'd15, 1, 1'b0, 32'h0,         STAT_OK,         0},
    '{REQ_READ,   1'b1, 32'h0,         4'd15, 1, 1'b0, 32'h0,         STAT_OK,         0},
    '{REQ_READ,   1'b1, 32'h0,         4'd0,  1, 1'b0, 32'h0,         STAT_OK,         0},
    '{REQ_REMOVE, 1'b1, 32'h5A5A_0003, 4'd0,  1, 1'b0, 32'h0,         STAT_OK,         0},
    '{REQ_READ,   1'b0, 32'h0,         4'd15, 1, 1'b1, 32'h0,         STAT_BAD_INDEX,  15},
    '{REQ_REMOVE, 1'b0, 32'hDEAD_BEEF, 4'd0,  1, 1'b1, 32'h0,         STAT_NOT_FOUND,  15},
    '{REQ_REMOVE, 1'b0, 32'hA5A5_0007, 4'd0,  1, 1'b0, 32'h0,         STAT_OK,         0},
    '{REQ_READ,   1'b1, 32'h0,         4'd14, 1, 1'b0, 32'h0,         STAT_OK,         0}
  };

  double_ended_queue dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (req_ready),
    .s_axis_tdata  (req_data),
    .s_axis_tuser  (req_user),
    .m_axis_tvalid (rsp_valid),
    .m_axis_tready (rsp_ready),
    .m_axis_tdata  (rsp_data),
    .m_axis_tuser  (rsp_user)
  );

  always #2 clk = ~clk;

  // The cycle count is split into windows; every fourth runs with no idling on either side.
  assign calm = ((cycles / 256) % 4) == 3;

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(3, 1);
    end else if (roll < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(30, 20);
  endfunction

  // Applies one request to the shadow queue and returns the result it yields.
  function automatic result_t deque_apply(req_t op, bit tail, logic [31:0] val,
                                          logic [3:0] pos);
    result_t r;
    int      hit;
    int      idx;
    r.word   = '0;
    r.status = STAT_OK;
    if (op == REQ_PUT) begin
      if (shadow_words.size() >= QUEUE_DEPTH) begin
        r.status = STAT_FULL;
      end else if (tail) begin
        shadow_words.push_back(val);
      end else begin
        shadow_words.push_front(val);
      end
    end else if (shadow_words.size() == 0) begin
      r.status = STAT_EMPTY;
    end else if (op == REQ_TAKE) begin
      r.word = tail ? shadow_words.pop_back() : shadow_words.pop_front();
    end else if (op == REQ_READ) begin
      if (pos >= shadow_words.size()) begin
        r.status = STAT_BAD_INDEX;
      end else begin
        r.word = tail ? shadow_words[shadow_words.size() - 1 - pos] : shadow_words[pos];
      end
    end else begin
      // Remove: the first match counted from the chosen end goes away.
      hit = -1;
      for (int j = 0; j < shadow_words.size() && hit < 0; j++) begin
        idx = tail ? shadow_words.size() - 1 - j : j;
        if (shadow_words[idx] == val) begin
          hit = idx;
        end
      end
      if (hit < 0) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        r.word = shadow_words[hit];
        shadow_words.delete(hit);
      end
    end
    r.length = LEN_W'(shadow_words.size());
    return r;
  endfunction

  // Presents one request after a random gap and returns at its accepting edge.
  // Valid stays high straight into the next request when no gap follows.
  task automatic send_request(req_t op, bit tail, logic [31:0] val, logic [3:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= {4'b0, pos, val};
    req_user  <= {tail, op};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(3) == 0) begin
      sink_gap   = pick_gap();
      rsp_ready  <= (sink_gap == 0);
      stall_left <= (sink_gap > 0) ? sink_gap - 1 : 0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Result checker: every accepted item must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: out_word %h status %0d length %0d",
               rsp_data[31:0], rsp_user, rsp_data[36:32]);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_data[31:0] !== oldest_result.word) begin
          $error("out_word: expected %h, got %h", oldest_result.word, rsp_data[31:0]);
          errors++;
        end
        if (rsp_user !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, rsp_user);
          errors++;
        end
        if (rsp_data[36:32] !== oldest_result.length) begin
          $error("length: expected %0d, got %0d", oldest_result.length, rsp_data[36:32]);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    result_t     predicted;
    req_t        op;
    bit          tail;
    logic [31:0] val;
    logic [3:0]  pos;
    int          roll;
    int          fill_pct;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed list. Repeated rows step the data word by one per repeat.
    foreach (plan[n]) begin
      for (int i = 0; i < plan[n].reps; i++) begin
        send_request(plan[n].op, plan[n].tail, plan[n].val + i, plan[n].pos);
        predicted = deque_apply(plan[n].op, plan[n].tail, plan[n].val + i, plan[n].pos);
        if (plan[n].typed) begin
          predicted = '{word: plan[n].want_word, status: plan[n].want_status,
                        length: plan[n].want_len[LEN_W-1:0]};
        end
        pending_results.push_back(predicted);
      end
    end

    // Random phase. The share of puts switches between low, even and high
    // every 40 requests, so the queue keeps filling up and running dry.
    fill_pct = 50;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k % 40 == 0) begin
        roll     = $urandom_range(2);
        fill_pct = (roll == 0) ? 15 : ((roll == 1) ? 50 : 85);
      end
      tail = 1'($urandom_range(1));
      op   = ($urandom_range(99) < fill_pct) ? REQ_PUT : req_t'($urandom_range(3, 1));

      // A small pool of values makes duplicates common, so a remove from
      // either end has a real choice to make.
      roll = $urandom_range(99);
      if (op == REQ_REMOVE && shadow_words.size() > 0 && roll < 70) begin
        val = shadow_words[$urandom_range(shadow_words.size() - 1)];
      end else if (roll < 80) begin
        val = $urandom_range(7);
      end else if (roll < 88) begin
        val = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0;
      end else begin
        val = $urandom();
      end

      if (shadow_words.size() > 0 && $urandom_range(99) < 70) begin
        pos = 4'($urandom_range(shadow_words.size() - 1));
      end else begin
        pos = 4'($urandom_range(15));
      end

      send_request(op, tail, val, pos);
      pending_results.push_back(deque_apply(op, tail, val, pos));
    end
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/deq_pkg.sv
rtl/core/deq_mem.sv
rtl/core/deq_addr.sv
rtl/core/deq_seq.sv
rtl/core/double_ended_queue.sv
tb/tb.sv
